>>> hdl/stable_priority_deferred_call_queue_top_defines.svh
// Assertion macros for the deferred call queue.
// Depends on nothing; included by the port checker.
`ifndef STABLE_PRIORITY_DEFERRED_CALL_QUEUE_TOP_DEFINES_SVH
`define STABLE_PRIORITY_DEFERRED_CALL_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SPDCQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SPDCQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/spdcq_pkg.sv
// Shared types and codes for the deferred call queue.
// No dependencies; imported by every module of the block.
package spdcq_pkg;

    localparam logic FUNC_QUEUE  = 1'b0;
    localparam logic FUNC_RETIRE = 1'b1;

    typedef enum logic [1:0] {
        ST_ACCEPTED   = 2'd0,
        ST_FULL       = 2'd1,
        ST_DISPATCHED = 2'd2,
        ST_EMPTY      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SCAN,
        S_INS_PUT,
        S_DRAIN,
        S_RESP
    } state_t;

    // One queue slot
    typedef struct packed {
        logic [15:0] handle;
        logic [7:0]  priority_val;
    } entry_t;

    // One result word handed to the output register
    typedef struct packed {
        logic [15:0] handle;
        logic [7:0]  priority_val;
        status_t     status;
        logic        last;
    } result_t;

endpackage

>>> hdl/stable_priority_deferred_call_queue_top.sv
// Top level of the stable priority deferred call queue.
// Depends on spdcq_pkg, spdcq_mem and spdcq_ctrl.
//
// Usage
//   Input channel (in_valid/in_ready) carries one word: func, call_handle,
//   call_priority. func queue inserts the handle behind every entry of equal or
//   higher priority; func retire drains the whole queue, highest priority first.
//   Output channel (out_valid/out_ready) carries result words: out_handle,
//   out_priority, status, is_last. A queue word gives one result (accepted or
//   full); a retire word gives one dispatched result per entry, the last one
//   flagged, or a single empty result.
// Operation
//   One word is worked on at a time, as the entries live in a single-port-pair
//   slot memory with registered read data. An insert shifts each queued entry
//   of lower priority back one slot from the tail; full and empty answers go
//   straight to the response. A drain primes the read as the retire is taken,
//   then hands out one entry per cycle while the output register has room.
// Reset and stall
//   Reset empties the queue (count to zero) and drops any waiting output word;
//   slot contents are left as they are and are never read before being written.
//   When out_ready is low the output register holds its word and the drain or
//   response pauses without loss; a new input word may still be taken while a
//   finished result waits.
module stable_priority_deferred_call_queue_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [15:0] call_handle,
    input  logic [7:0]  call_priority,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] out_handle,
    output logic [7:0]  out_priority,
    output logic [1:0]  status,
    output logic        is_last
);
    import spdcq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    logic          res_valid;
    result_t       res;
    logic          res_free;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    entry_t        mem_rdata;

    logic          out_valid_reg, out_valid_next;
    result_t       out_word_reg, out_word_next;

    spdcq_mem #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    spdcq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .call_handle   (call_handle),
        .call_priority (call_priority),
        .res_valid     (res_valid),
        .res           (res),
        .res_free      (res_free),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_re        (mem_re),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata)
    );

    // The output register can take a word when empty or being emptied this cycle
    assign res_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
            out_word_next  = res;
        end
        else if (out_ready)
        begin
            // Drop the word once taken
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_handle   = out_word_reg.handle;
    assign out_priority = out_word_reg.priority_val;
    assign status       = out_word_reg.status;
    assign is_last      = out_word_reg.last;

endmodule

>>> hdl/spdcq_mem.sv
// Slot memory: one write port, one read port, registered read data.
// Depends on spdcq_pkg for the entry type.
module spdcq_mem #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                           clk,
    input  logic                           we,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] waddr,
    input  spdcq_pkg::entry_t              wdata,
    input  logic                           re,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] raddr,
    output spdcq_pkg::entry_t              rdata
);
    import spdcq_pkg::*;

    entry_t slots [QUEUE_DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            slots[waddr] <= wdata;
        end
    end

    // Hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= slots[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/spdcq_ctrl.sv
// Sequencer: tail-first insertion shift and in-order drain over the slot memory.
// Depends on spdcq_pkg and drives spdcq_mem.
module spdcq_ctrl #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           func,
    input  logic [15:0]                    call_handle,
    input  logic [7:0]                     call_priority,
    output logic                           res_valid,
    output spdcq_pkg::result_t             res,
    input  logic                           res_free,
    output logic                           mem_we,
    output logic [$clog2(QUEUE_DEPTH)-1:0] mem_waddr,
    output spdcq_pkg::entry_t              mem_wdata,
    output logic                           mem_re,
    output logic [$clog2(QUEUE_DEPTH)-1:0] mem_raddr,
    input  spdcq_pkg::entry_t              mem_rdata
);
    import spdcq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [15:0]   item_handle_reg, item_handle_next;
    logic [7:0]    item_prio_reg, item_prio_next;
    status_t       resp_status_reg, resp_status_next;
    entry_t        new_entry;
    logic          drain_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        item_handle_reg <= item_handle_next;
        item_prio_reg   <= item_prio_next;
        resp_status_reg <= resp_status_next;
    end

    assign new_entry  = '{handle: item_handle_reg, priority_val: item_prio_reg};
    assign drain_last = ((CW'(idx_reg) + CW'(1)) == cnt_reg);

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        idx_next         = idx_reg;
        item_handle_next = item_handle_reg;
        item_prio_next   = item_prio_reg;
        resp_status_next = resp_status_reg;
        in_ready         = 1'b0;
        res_valid        = 1'b0;
        res              = '{handle: item_handle_reg, priority_val: item_prio_reg,
                             status: resp_status_reg, last: 1'b1};
        mem_we           = 1'b0;
        mem_waddr        = idx_reg;
        mem_wdata        = new_entry;
        mem_re           = 1'b0;
        mem_raddr        = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (func == FUNC_QUEUE)
                    begin
                        item_handle_next = call_handle;
                        item_prio_next   = call_priority;
                        if (cnt_reg == CW'(QUEUE_DEPTH))
                        begin
                            resp_status_next = ST_FULL;
                            state_next       = S_RESP;
                        end
                        else if (cnt_reg == '0)
                        begin
                            idx_next   = '0;
                            state_next = S_INS_PUT;
                        end
                        else
                        begin
                            // Start at the tail; the hole sits at the current count
                            mem_re     = 1'b1;
                            mem_raddr  = AW'(cnt_reg - CW'(1));
                            idx_next   = AW'(cnt_reg);
                            state_next = S_INS_SCAN;
                        end
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            item_handle_next = '0;
                            item_prio_next   = '0;
                            resp_status_next = ST_EMPTY;
                            state_next       = S_RESP;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = '0;
                            idx_next   = '0;
                            state_next = S_DRAIN;
                        end
                    end
                end
            end

            S_INS_SCAN:
            begin
                // mem_rdata holds the slot just ahead of the hole
                mem_we = 1'b1;
                if (mem_rdata.priority_val >= item_prio_reg)
                begin
                    cnt_next         = cnt_reg + CW'(1);
                    resp_status_next = ST_ACCEPTED;
                    state_next       = S_RESP;
                end
                else
                begin
                    // Move the lower-priority entry back one slot
                    mem_wdata = mem_rdata;
                    idx_next  = idx_reg - AW'(1);
                    if (idx_reg == AW'(1))
                    begin
                        state_next = S_INS_PUT;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = idx_reg - AW'(2);
                    end
                end
            end

            S_INS_PUT:
            begin
                mem_we           = 1'b1;
                cnt_next         = cnt_reg + CW'(1);
                resp_status_next = ST_ACCEPTED;
                state_next       = S_RESP;
            end

            S_DRAIN:
            begin
                if (res_free)
                begin
                    res_valid = 1'b1;
                    res       = '{handle: mem_rdata.handle,
                                  priority_val: mem_rdata.priority_val,
                                  status: ST_DISPATCHED, last: drain_last};
                    if (drain_last)
                    begin
                        cnt_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = idx_reg + AW'(1);
                        idx_next  = idx_reg + AW'(1);
                    end
                end
            end

            S_RESP:
            begin
                if (res_free)
                begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/spdcq_chk.sv
// Port-level checker for the deferred call queue, bound to the top level.
// Depends on spdcq_pkg and the assertion macros header.
`include "stable_priority_deferred_call_queue_top_defines.svh"

module spdcq_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_handle,
    input logic [7:0]  out_priority,
    input logic [1:0]  status,
    input logic        is_last
);
    import spdcq_pkg::*;

    // A stalled result word holds
    `SPDCQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(out_handle) && $stable(out_priority)
        && $stable(status) && $stable(is_last),
        "stalled result word changed")

    // One word at a time: ready drops after each accept
    `SPDCQ_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready,
        "input taken while busy")

    // Insert answers are single results
    `SPDCQ_ASSERT_NOW(a_insert_last,
        out_valid && (status == ST_ACCEPTED || status == ST_FULL), is_last,
        "insert answer not flagged last")

    // Empty answer carries zero fields and ends the item
    `SPDCQ_ASSERT_NOW(a_empty_zero, out_valid && status == ST_EMPTY,
        is_last && out_handle == '0 && out_priority == '0,
        "empty answer malformed")

endmodule

bind stable_priority_deferred_call_queue_top spdcq_chk u_spdcq_chk (.*);

>>> bench/stable_priority_deferred_call_queue_top_test.sv
// Self-checking testbench for stable_priority_deferred_call_queue_top.
// Depends on spdcq_pkg and the block's RTL. It predicts every result word from
// its own copy of the sorted queue and checks each word at the output handshake.
`timescale 1ns / 100ps

module stable_priority_deferred_call_queue_top_test;

    import spdcq_pkg::*;

    localparam int QDEPTH       = 16;
    localparam int RANDOM_WORDS = 186;
    localparam int HOLD_AT_WORD = 60;     // words in before the long output hold
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 60;     // settle time once nothing is due
    localparam int CYCLE_LIMIT  = 200000;

    // One input word as the sender offers it; wait_idle makes the sender
    // hold the word back until every due result has come out.
    typedef struct {
        logic        func;
        logic [15:0] handle;
        logic [7:0]  prio;
        bit          wait_idle;
    } call_word_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic        func          = FUNC_QUEUE;
    logic [15:0] call_handle   = 16'h0000;
    logic [7:0]  call_priority = 8'h00;
    logic        out_valid;
    logic        out_ready     = 1'b0;
    logic [15:0] out_handle;
    logic [7:0]  out_priority;
    logic [1:0]  status;
    logic        is_last;

    // Stimulus still to be offered, and results predicted but not yet seen
    call_word_t  pending_calls[$];
    result_t     due_results[$];

    // Predicted contents of the queue, highest priority first
    logic [15:0] stored_handle [QDEPTH];
    logic [7:0]  stored_prio   [QDEPTH];
    int          stored_count  = 0;

    logic        in_fire       = 1'b0;    // word taken at the last rising edge
    int          words_in      = 0;
    int          results_seen  = 0;
    int          status_seen [4];
    int          errors        = 0;
    int          cycle_count   = 0;

    int          burst_left    = 0;
    int          gap_left      = 0;
    int          rx_cycle      = 0;
    int          hold_left     = 0;
    bit          hold_done     = 1'b0;

    stable_priority_deferred_call_queue_top #(
        .QUEUE_DEPTH (QDEPTH)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .call_handle   (call_handle),
        .call_priority (call_priority),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_handle    (out_handle),
        .out_priority  (out_priority),
        .status        (status),
        .is_last       (is_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Work out the result words of one accepted input word and advance the
    // predicted queue. A new entry goes behind every entry of equal or higher
    // priority, so ties leave in arrival order.
    function automatic void predict_call_word(input call_word_t w);
        result_t r;
        int      pos;
        r.handle       = w.handle;
        r.priority_val = w.prio;
        r.last         = 1'b1;
        if (w.func == FUNC_QUEUE) begin
            if (stored_count >= QDEPTH) begin
                r.status = ST_FULL;
            end
            else begin
                pos = 0;
                while (pos < stored_count && stored_prio[pos] >= w.prio)
                    pos++;
                for (int i = stored_count; i > pos; i--) begin
                    stored_handle[i] = stored_handle[i - 1];
                    stored_prio[i]   = stored_prio[i - 1];
                end
                stored_handle[pos] = w.handle;
                stored_prio[pos]   = w.prio;
                stored_count++;
                r.status = ST_ACCEPTED;
            end
            due_results.push_back(r);
        end
        else if (stored_count == 0) begin
            // Retire on an empty queue: a single empty status, zero fields
            r.handle       = 16'h0000;
            r.priority_val = 8'h00;
            r.status       = ST_EMPTY;
            due_results.push_back(r);
        end
        else begin
            for (int i = 0; i < stored_count; i++) begin
                r.handle       = stored_handle[i];
                r.priority_val = stored_prio[i];
                r.status       = ST_DISPATCHED;
                r.last         = (i == stored_count - 1);
                due_results.push_back(r);
            end
            stored_count = 0;
        end
    endfunction

    // Compare the word on the output port with the oldest due result
    task automatic check_result_word();
        result_t want;
        if (due_results.size() == 0) begin
            errors++;
            $display("%0t: result word with none due: handle %h priority %h status %0d last %b",
                     $time, out_handle, out_priority, status, is_last);
        end
        else begin
            want = due_results.pop_front();
            if (out_handle !== want.handle) begin
                errors++;
                $display("%0t: out_handle expected %h actual %h",
                         $time, want.handle, out_handle);
            end
            if (out_priority !== want.priority_val) begin
                errors++;
                $display("%0t: out_priority expected %h actual %h",
                         $time, want.priority_val, out_priority);
            end
            if (status !== want.status) begin
                errors++;
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, status);
            end
            if (is_last !== want.last) begin
                errors++;
                $display("%0t: is_last expected %b actual %b",
                         $time, want.last, is_last);
            end
        end
    endtask

    task automatic add_call(input logic f, input logic [15:0] h, input logic [7:0] p,
                            input bit wait_idle);
        call_word_t w;
        w.func      = f;
        w.handle    = h;
        w.prio      = p;
        w.wait_idle = wait_idle;
        pending_calls.push_back(w);
    endtask

    // Monitor: sample both handshakes at the rising edge. Predict on the
    // input side, check on the output side.
    always @(posedge clk)
    begin
        in_fire <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready) begin
            predict_call_word('{func, call_handle, call_priority, 1'b0});
            words_in++;
        end
        if (rst_n && out_valid && out_ready) begin
            check_result_word();
            results_seen++;
            status_seen[status]++;
        end
    end

    // Sender: change inputs at the falling edge. Hold a word until it is
    // taken, then either sit out a gap or offer the next word of the burst.
    always @(negedge clk)
    begin : drive_calls
        call_word_t w;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else if (in_valid && !in_fire) begin
            // hold the word and its payload until accepted
        end
        else if (gap_left > 0) begin
            gap_left--;
            in_valid <= 1'b0;
        end
        else if (pending_calls.size() != 0 &&
                 !(pending_calls[0].wait_idle && due_results.size() != 0)) begin
            w = pending_calls.pop_front();
            func          <= w.func;
            call_handle   <= w.handle;
            call_priority <= w.prio;
            in_valid      <= 1'b1;
            if (burst_left > 0) begin
                burst_left--;
            end
            else begin
                // close the burst; about a third of bursts run straight on
                burst_left = $urandom_range(0, 15);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
        end
        else begin
            in_valid <= 1'b0;
        end
    end

    // Receiver: a stall pattern that steps through four modes in turn, and once a
    // long hold while the sender keeps offering, so the block backs up.
    always @(negedge clk)
    begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (!hold_done && words_in >= HOLD_AT_WORD) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end
        else begin
            case ((rx_cycle / 90) % 4)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 1) == 1);
                2:       out_ready <= (rx_cycle % 3 == 0);
                default: out_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
        rx_cycle++;
    end

    // Watchdog: end the run if it goes far beyond any correct run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d results still due",
                 cycle_count, due_results.size());
        $display("[stable_priority_deferred_call_queue_top] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int         random_count;
        int         run;
        int         tie_mode;
        logic [7:0] base_prio;
        logic [7:0] p;
        bit         pause;
        logic [7:0] fill_prio [16];

        foreach (status_seen[i])
            status_seen[i] = 0;

        // Directed: retire on an empty queue, field extremes, a tie, a drain
        add_call(FUNC_RETIRE, 16'h0000, 8'h00, 1'b0);
        add_call(FUNC_QUEUE,  16'h0000, 8'h00, 1'b0);
        add_call(FUNC_QUEUE,  16'hFFFF, 8'hFF, 1'b0);
        add_call(FUNC_QUEUE,  16'hA5A5, 8'h64, 1'b0);
        add_call(FUNC_QUEUE,  16'h5A5A, 8'h64, 1'b0);
        add_call(FUNC_RETIRE, 16'hFFFF, 8'hFF, 1'b0);

        // Directed: fill to depth with ties at the top, bottom and middle,
        // push one more to hit the full answer, then drain all sixteen
        fill_prio = '{8'hFF, 8'h00, 8'h80, 8'h80, 8'hFF, 8'h07, 8'hC8, 8'h80,
                      8'h00, 8'hFF, 8'h40, 8'hC8, 8'h01, 8'h80, 8'hFE, 8'h40};
        for (int k = 0; k < 16; k++)
            add_call(FUNC_QUEUE, 16'(16'h0100 + k), fill_prio[k], 1'b0);
        add_call(FUNC_QUEUE,  16'hBEEF, 8'hFF, 1'b0);
        add_call(FUNC_RETIRE, 16'h0000, 8'h00, 1'b0);

        // Random: runs of inserts closed by a retire. Priorities come from
        // the full range, a narrow band (many ties) or a single value.
        random_count = 0;
        pause        = 1'b1;
        while (random_count < RANDOM_WORDS) begin
            case ($urandom_range(0, 9))
                0:       run = $urandom_range(16, 19);
                1:       run = 0;
                default: run = $urandom_range(1, 8);
            endcase
            tie_mode  = $urandom_range(0, 2);
            base_prio = 8'($urandom_range(0, 255));
            for (int k = 0; k < run; k++) begin
                case (tie_mode)
                    0:       p = 8'($urandom_range(0, 255));
                    1:       p = base_prio ^ 8'($urandom_range(0, 3));
                    default: p = base_prio;
                endcase
                add_call(FUNC_QUEUE, 16'($urandom_range(0, 65535)), p, pause);
                pause = 1'b0;
            end
            // now and then an extra retire goes first, so the closing retire finds the queue empty
            if ($urandom_range(0, 7) == 0) begin
                add_call(FUNC_RETIRE, 16'($urandom_range(0, 65535)),
                         8'($urandom_range(0, 255)), pause);
                pause = 1'b0;
                random_count++;
            end
            add_call(FUNC_RETIRE, 16'($urandom_range(0, 65535)),
                     8'($urandom_range(0, 255)), pause);
            random_count += run + 1;
            pause = ($urandom_range(0, 19) == 0);
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain: wait for every word to go in and every result to come out
        while (pending_calls.size() != 0 || in_valid || due_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d input words and %0d result words in %0d cycles",
                 words_in, results_seen, cycle_count);
        $display("  accepted %0d, full %0d, dispatched %0d, empty %0d; %0d mismatches",
                 status_seen[ST_ACCEPTED], status_seen[ST_FULL],
                 status_seen[ST_DISPATCHED], status_seen[ST_EMPTY], errors);
        if (errors == 0 && due_results.size() == 0)
            $display("[stable_priority_deferred_call_queue_top] OK");
        else
            $display("[stable_priority_deferred_call_queue_top] ERROR");
        $finish;
    end

endmodule
